// ===== hdl/ppia_pkg.sv =====
// shared types, constants and aes-128 round functions for the ipv6 anonymizer
// no dependencies
`timescale 1ns / 1ps

package ppia_pkg;

	localparam int ADDR_W    = 128;
	localparam int HALF_W    = 64;
	localparam int POS_W     = 7;
	localparam int NUM_POS   = 128;
	localparam int AES_RNDS  = 10;

	typedef enum logic [1:0] {
		CFG_KEY_HIGH = 2'd0,
		CFG_KEY_LOW  = 2'd1,
		CFG_PAD_HIGH = 2'd2,
		CFG_PAD_LOW  = 2'd3
	} cfg_idx_t;

	// travels with each block through the cipher pipeline
	typedef struct packed {
		logic             last;
		logic [POS_W-1:0] pos;
	} ppia_tag_t;

	localparam logic [7:0] RCON [AES_RNDS] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// next round key; byte 0 sits in the top 8 bits
	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
		w0 = rk[127:96] ^ t;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// one full round: sub bytes, shift rows, mix columns unless last, add round key
	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
		input logic last);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[4*c+r] = SBOX[s[4*((c+r)&3)+r]];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
		return res;
	endfunction

endpackage

// ===== hdl/ppia_if.sv =====
// stream interfaces for addresses in and anonymized addresses out
// no dependencies
`timescale 1ns / 1ps

interface ppia_addr_if;
	logic        valid;
	logic        ready;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	modport source(output valid, output addr_high, output addr_low, input ready);
	modport sink(input valid, input addr_high, input addr_low, output ready);
endinterface

interface ppia_anon_if;
	logic        valid;
	logic        ready;
	logic [63:0] anon_high;
	logic [63:0] anon_low;
	modport source(output valid, output anon_high, output anon_low, input ready);
	modport sink(input valid, input anon_high, input anon_low, output ready);
endinterface

// ===== hdl/ppia_front.sv =====
// front end: takes addresses off the input channel into a two-entry queue
// depends on ppia_pkg
`timescale 1ns / 1ps

module ppia_front import ppia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              q_valid,
	output logic [ADDR_W-1:0] q_addr,
	input  logic              q_pop
);

	logic [ADDR_W-1:0] mem_q [2];
	logic              wptr_q, rptr_q;
	logic [1:0]        cnt_q;
	logic              push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_addr   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= in_addr;
	end

endmodule

// ===== hdl/ppia_aes_pipe.sv =====
// fully unrolled aes-128 encryption pipeline, one round per stage, key expanded alongside
// depends on ppia_pkg
`timescale 1ns / 1ps

module ppia_aes_pipe import ppia_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  ppia_tag_t    in_tag,
	input  logic [127:0] in_blk,
	input  logic [127:0] in_key,
	output logic         out_valid,
	output ppia_tag_t    out_tag,
	output logic         out_msb
);

	logic         vld_s [AES_RNDS+1];
	ppia_tag_t    tag_s [AES_RNDS+1];
	logic [127:0] blk_s [AES_RNDS+1];
	logic [127:0] key_s [AES_RNDS+1];

	// initial add round key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		blk_s[0] <= in_blk ^ in_key;
		key_s[0] <= in_key;
	end

	for (genvar g = 1; g <= AES_RNDS; g++) begin : g_rnd
		logic [127:0] nk;
		assign nk = key_next(key_s[g-1], RCON[g-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g] <= 1'b0;
			else vld_s[g] <= vld_s[g-1];
		end

		always_ff @(posedge clk) begin
			tag_s[g] <= tag_s[g-1];
			blk_s[g] <= aes_round(blk_s[g-1], nk, (g == AES_RNDS));
			key_s[g] <= nk;
		end
	end

	assign out_valid = vld_s[AES_RNDS];
	assign out_tag   = tag_s[AES_RNDS];
	assign out_msb   = blk_s[AES_RNDS][127];

endmodule

// ===== hdl/ppia_back.sv =====
// back end: issues one block per bit position, collects ciphertext top bits, output queue
// depends on ppia_pkg and ppia_aes_pipe
`timescale 1ns / 1ps

module ppia_back import ppia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  logic [ADDR_W-1:0] q_addr,
	output logic              q_pop,
	input  logic [127:0]      key,
	input  logic [127:0]      pad,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] out_data
);

	logic              busy_q;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] col_addr_q;
	logic [ADDR_W-1:0] acc_q;
	logic [1:0]        inflight_q;
	logic [1:0]        ocnt_q;
	logic [ADDR_W-1:0] omem_q [2];
	logic              owptr_q, orptr_q;

	logic              last_pos;
	logic              can_load;
	logic [ADDR_W-1:0] mask;
	ppia_tag_t         iss_tag;
	logic [127:0]      iss_blk;
	logic              res_valid;
	ppia_tag_t         res_tag;
	logic              res_msb;
	logic [ADDR_W-1:0] acc_nxt;
	logic              opush, opop;

	assign last_pos = (pos_q == POS_W'(NUM_POS - 1));
	// a new address only starts once its result has a guaranteed queue slot
	assign can_load = q_valid && ({1'b0, inflight_q} + {1'b0, ocnt_q} < 3'd2)
		&& (!busy_q || last_pos);
	assign q_pop    = can_load;

	// first pos bits come from the address, the rest from the pad
	assign mask     = ~({ADDR_W{1'b1}} >> pos_q);
	assign iss_blk  = (addr_q & mask) | (pad & ~mask);
	assign iss_tag  = '{last: last_pos, pos: pos_q};

	ppia_aes_pipe u_aes (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (busy_q),
		.in_tag    (iss_tag),
		.in_blk    (iss_blk),
		.in_key    (key),
		.out_valid (res_valid),
		.out_tag   (res_tag),
		.out_msb   (res_msb)
	);

	always_comb begin
		acc_nxt = (res_tag.pos == '0) ? '0 : acc_q;
		acc_nxt[POS_W'(NUM_POS - 1) - res_tag.pos] = res_msb;
	end

	assign opush     = res_valid && res_tag.last;
	assign out_valid = (ocnt_q != 2'd0);
	assign opop      = out_valid && out_ready;
	assign out_data  = omem_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pos_q      <= '0;
			inflight_q <= 2'd0;
			ocnt_q     <= 2'd0;
			owptr_q    <= 1'b0;
			orptr_q    <= 1'b0;
		end else begin
			if (can_load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (busy_q) begin
				if (last_pos) busy_q <= 1'b0;
				pos_q <= pos_q + 1'b1;
			end
			inflight_q <= inflight_q + {1'b0, can_load} - {1'b0, opush};
			ocnt_q     <= ocnt_q + {1'b0, opush} - {1'b0, opop};
			if (opush) owptr_q <= ~owptr_q;
			if (opop) orptr_q <= ~orptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) addr_q <= q_addr;
		// collection of one address ends long before the next one issues its last block
		if (busy_q && last_pos) col_addr_q <= addr_q;
		if (res_valid) acc_q <= acc_nxt;
		if (opush) omem_q[owptr_q] <= col_addr_q ^ acc_nxt;
	end

endmodule

// ===== hdl/prefix_preserving_ipv6_anonymizer.sv =====
// prefix-preserving ipv6 anonymizer (aes-128 based), top level
// addresses enter on req, anonymized addresses leave on rsp; config regs hold key and pad
// the front queue feeds a back end that runs 128 blocks per address through an 11-stage
// aes pipeline, one block a cycle
// blocks enter the cipher pipeline one per cycle (one block per bit position); the back
// end loads the next address while issuing the current one's last block, given queue room
// an address is loaded from the front queue, issued as 128 blocks, passed through the
// 11 pipeline stages, and pushed into the output queue with its last block's result
// up to two addresses wait in the front queue, so req is taken while earlier ones run
// a stalled rsp holds its data; the back end starts a new address only when the
// two-entry output queue has room for it, so nothing is dropped
// reset empties both queues and the pipeline and clears key and pad to zero
// key and pad are written through cfg_we/cfg_index/cfg_data, by the user only while idle;
// the block does not enforce this; depends on ppia_pkg, ppia_if, ppia_front, ppia_back
`timescale 1ns / 1ps

module prefix_preserving_ipv6_anonymizer import ppia_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	ppia_addr_if.sink     req,
	ppia_anon_if.source   rsp
);

	logic [HALF_W-1:0] key_high_q, key_low_q, pad_high_q, pad_low_q;
	logic              q_valid, q_pop;
	logic [ADDR_W-1:0] q_addr;
	logic [ADDR_W-1:0] out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			pad_high_q <= '0;
			pad_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_PAD_HIGH: pad_high_q <= cfg_data;
				CFG_PAD_LOW:  pad_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ppia_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_addr  ({req.addr_high, req.addr_low}),
		.q_valid  (q_valid),
		.q_addr   (q_addr),
		.q_pop    (q_pop)
	);

	ppia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_addr    (q_addr),
		.q_pop     (q_pop),
		.key       ({key_high_q, key_low_q}),
		.pad       ({pad_high_q, pad_low_q}),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

	assign rsp.anon_high = out_data[ADDR_W-1:HALF_W];
	assign rsp.anon_low  = out_data[HALF_W-1:0];

endmodule

// ===== hdl/ppia_checker.sv =====
// port-level checks for the anonymizer top level, bound to it below
// depends on prefix_preserving_ipv6_anonymizer
`timescale 1ns / 1ps

module ppia_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] anon_high,
	input logic [63:0] anon_low
);

	// addresses taken but not yet delivered
	logic [3:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_q <= '0;
		else pending_q <= pending_q + {3'd0, req_valid && req_ready}
			- {3'd0, rsp_valid && rsp_ready};
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(anon_high) && $stable(anon_low))
		else $error("rsp data changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 4'd0)
		else $error("result without an outstanding address");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd6)
		else $error("more addresses in flight than the design can hold");

endmodule

bind prefix_preserving_ipv6_anonymizer ppia_checker u_ppia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.anon_high (rsp.anon_high),
	.anon_low  (rsp.anon_low)
);
